### rtl/dmx_pkg.sv
// Shared types, constants and helpers for the DMX512 frame transmit sequencer.
package dmx_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 512;
  localparam int unsigned MIN_SLOTS     = 24;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned WAIT_W    = 7;
  localparam int unsigned WCNT_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [WAIT_W-1:0] DATA_END_WAIT_RST = WAIT_W'(50);
  localparam logic [WAIT_W-1:0] BREAK_WAIT_RST    = WAIT_W'(80);

  localparam logic RATE_BREAK = 1'b0;
  localparam logic RATE_DATA  = 1'b1;
  localparam logic FMT_8E1    = 1'b0;
  localparam logic FMT_8N2    = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_EMPTY   = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT    = 2'd0,
    REG_DATA_END_WAIT = 2'd1,
    REG_BREAK_WAIT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    PH_BREAK      = 5'b00001,
    PH_START      = 5'b00010,
    PH_DATA       = 5'b00100,
    PH_IDLE       = 5'b01000,
    PH_BREAK_SENT = 5'b10000
  } phase_e;

  localparam logic [PHASE_W-1:0] CODE_BREAK      = 3'd0;
  localparam logic [PHASE_W-1:0] CODE_START      = 3'd1;
  localparam logic [PHASE_W-1:0] CODE_DATA       = 3'd2;
  localparam logic [PHASE_W-1:0] CODE_IDLE       = 3'd3;
  localparam logic [PHASE_W-1:0] CODE_BREAK_SENT = 3'd4;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

  function automatic logic [PHASE_W-1:0] phase_code(phase_e ph);
    logic [PHASE_W-1:0] c;
    case (ph)
      PH_START:      c = CODE_START;
      PH_DATA:       c = CODE_DATA;
      PH_IDLE:       c = CODE_IDLE;
      PH_BREAK_SENT: c = CODE_BREAK_SENT;
      default:       c = CODE_BREAK;
    endcase
    return c;
  endfunction

endpackage

### rtl/dmx_intf.sv
// Handshake channel interfaces for requests, results and register writes.
interface dmx_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmx_pkg::FUNC_W-1:0]  func;
  logic [dmx_pkg::IDX_W-1:0]   slot_index;
  logic [dmx_pkg::BYTE_W-1:0]  slot_value;
  modport source (output valid, func, slot_index, slot_value, input ready);
  modport sink (input valid, func, slot_index, slot_value, output ready);
endinterface

interface dmx_out_if;
  logic                        valid;
  logic                        ready;
  logic                        tx_valid;
  logic [dmx_pkg::BYTE_W-1:0]  tx_byte;
  logic                        line_rate;
  logic                        frame_format;
  logic [dmx_pkg::BYTE_W-1:0]  read_value;
  logic [dmx_pkg::PHASE_W-1:0] frame_phase;
  modport source (output valid, tx_valid, tx_byte, line_rate, frame_format, read_value,
                  frame_phase, input ready);
  modport sink (input valid, tx_valid, tx_byte, line_rate, frame_format, read_value,
                frame_phase, output ready);
endinterface

interface dmx_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dmx_pkg::CFG_IDX_W-1:0] index;
  logic [dmx_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/dmx_slot_ram.sv
// Slot byte store: one write port, one registered read port, clearing pass after reset.
module dmx_slot_ram #(
  parameter int unsigned DEPTH = dmx_pkg::MAX_SLOTS_DEF + 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dmx_pkg::ram_ctl_t          ctl_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [dmx_pkg::BYTE_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [dmx_pkg::BYTE_W-1:0] rdata_o,
  output logic                       busy_o
);

  logic [dmx_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [dmx_pkg::BYTE_W-1:0] rdata_q;
  logic                       busy_q;
  logic [AW-1:0]              clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

### rtl/dmx512_frame_transmit_sequencer.sv
// DMX512 frame transmit sequencer: phase machine, slot store access and result register.
// An accepted request goes through the read stage, then the result register, to the output.
// Throughput: one request per cycle while results are taken; the slot store read is registered
// at the accept. Reset: phase, counters and registers go to their defaults at once; the slot
// store is then cleared one entry per cycle, all MAX_SLOTS + 1 entries (513 by default), while no
// request is taken. Register writes are taken throughout.
module dmx512_frame_transmit_sequencer #(
  parameter int unsigned MAX_SLOTS = dmx_pkg::MAX_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dmx_in_if.sink     in_if,
  dmx_out_if.source  out_if,
  dmx_cfg_if.sink    cfg_if
);

  localparam int unsigned DEPTH = MAX_SLOTS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [dmx_pkg::IDX_W-1:0] MAX_IDX = dmx_pkg::IDX_W'(MAX_SLOTS);
  localparam logic [dmx_pkg::IDX_W-1:0] MIN_IDX = dmx_pkg::IDX_W'(dmx_pkg::MIN_SLOTS);

  // configuration
  logic [dmx_pkg::IDX_W-1:0]  slot_count_q;
  logic [dmx_pkg::WAIT_W-1:0] data_end_wait_q;
  logic [dmx_pkg::WAIT_W-1:0] break_wait_q;
  logic [dmx_pkg::IDX_W-1:0]  cfg_sat;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_sat = cfg_if.data;
    if (cfg_sat < MIN_IDX) begin
      cfg_sat = MIN_IDX;
    end
    if (cfg_sat > MAX_IDX) begin
      cfg_sat = MAX_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q    <= MAX_IDX;
      data_end_wait_q <= dmx_pkg::DATA_END_WAIT_RST;
      break_wait_q    <= dmx_pkg::BREAK_WAIT_RST;
    end else if (cfg_if.valid) begin
      case (dmx_pkg::cfg_reg_e'(cfg_if.index))
        dmx_pkg::REG_SLOT_COUNT:    slot_count_q <= cfg_sat;
        dmx_pkg::REG_DATA_END_WAIT: data_end_wait_q <= cfg_if.data[dmx_pkg::WAIT_W-1:0];
        dmx_pkg::REG_BREAK_WAIT:    break_wait_q <= cfg_if.data[dmx_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, out_valid_q;
  logic ram_busy, in_acc, s1_adv;

  assign s1_adv      = s1_valid_q & (~out_valid_q | out_if.ready);
  assign in_if.ready = ~ram_busy & (~s1_valid_q | ~out_valid_q | out_if.ready);
  assign in_acc      = in_if.valid & in_if.ready;

  // phase machine
  dmx_pkg::phase_e            phase_q, phase_d;
  logic [dmx_pkg::IDX_W-1:0]  next_slot_q, next_slot_d, slot_inc;
  logic [dmx_pkg::WCNT_W-1:0] wait_q, wait_d, wait_inc;
  logic                       rate_q, rate_d, fmt_q, fmt_d;
  logic                       tx_v, tx_mem, rd_mem, wr_req;
  logic [dmx_pkg::IDX_W-1:0]  raddr;
  logic                       raddr_oob;

  assign slot_inc  = next_slot_q + dmx_pkg::IDX_W'(1);
  assign wait_inc  = (wait_q == '1) ? wait_q : wait_q + dmx_pkg::WCNT_W'(1);
  assign raddr_oob = raddr > MAX_IDX;

  always_comb begin
    phase_d     = phase_q;
    next_slot_d = next_slot_q;
    wait_d      = wait_q;
    rate_d      = rate_q;
    fmt_d       = fmt_q;
    tx_v        = 1'b0;
    tx_mem      = 1'b0;
    rd_mem      = 1'b0;
    wr_req      = 1'b0;
    raddr       = in_if.slot_index;
    case (dmx_pkg::func_e'(in_if.func))
      dmx_pkg::FUNC_WRITE: wr_req = in_if.slot_index <= MAX_IDX;
      dmx_pkg::FUNC_READ:  rd_mem = 1'b1;
      dmx_pkg::FUNC_RESTART: begin
        phase_d = dmx_pkg::PH_BREAK;
        wait_d  = '0;
        rate_d  = dmx_pkg::RATE_BREAK;
        fmt_d   = dmx_pkg::FMT_8E1;
      end
      default: begin
        case (phase_q)
          dmx_pkg::PH_START: begin
            rate_d      = dmx_pkg::RATE_DATA;
            fmt_d       = dmx_pkg::FMT_8N2;
            tx_v        = 1'b1;
            tx_mem      = 1'b1;
            raddr       = '0;
            next_slot_d = dmx_pkg::IDX_W'(1);
            phase_d     = dmx_pkg::PH_DATA;
          end
          dmx_pkg::PH_DATA: begin
            tx_v        = 1'b1;
            tx_mem      = 1'b1;
            raddr       = next_slot_q;
            next_slot_d = slot_inc;
            if (slot_inc > slot_count_q) begin
              phase_d = dmx_pkg::PH_IDLE;
              wait_d  = '0;
            end
          end
          dmx_pkg::PH_IDLE: begin
            wait_d = wait_inc;
            if (wait_inc > {1'b0, data_end_wait_q}) begin
              phase_d = dmx_pkg::PH_BREAK;
            end
          end
          dmx_pkg::PH_BREAK_SENT: begin
            wait_d = wait_inc;
            if (wait_inc > {1'b0, break_wait_q}) begin
              phase_d = dmx_pkg::PH_START;
            end
          end
          default: begin
            rate_d  = dmx_pkg::RATE_BREAK;
            fmt_d   = dmx_pkg::FMT_8E1;
            tx_v    = 1'b1;
            wait_d  = '0;
            phase_d = dmx_pkg::PH_BREAK_SENT;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dmx_pkg::PH_BREAK;
      next_slot_q <= '0;
      wait_q      <= '0;
      rate_q      <= dmx_pkg::RATE_BREAK;
      fmt_q       <= dmx_pkg::FMT_8E1;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      next_slot_q <= next_slot_d;
      wait_q      <= wait_d;
      rate_q      <= rate_d;
      fmt_q       <= fmt_d;
    end
  end

  // slot store
  dmx_pkg::ram_ctl_t          ram_ctl;
  logic [dmx_pkg::BYTE_W-1:0] ram_rdata;

  assign ram_ctl.wr_en = in_acc & wr_req;
  assign ram_ctl.rd_en = in_acc & (tx_mem | rd_mem) & ~raddr_oob;

  dmx_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ram_ctl),
    .waddr_i (in_if.slot_index[AW-1:0]),
    .wdata_i (in_if.slot_value),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (ram_rdata),
    .busy_o  (ram_busy)
  );

  // read stage
  logic                        s1_tx_v_q, s1_tx_mem_q, s1_rd_mem_q, s1_oob_q;
  logic                        s1_rate_q, s1_fmt_q;
  logic [dmx_pkg::PHASE_W-1:0] s1_phase_q;
  logic [dmx_pkg::BYTE_W-1:0]  mem_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc | (s1_valid_q & ~s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_tx_v_q   <= tx_v;
      s1_tx_mem_q <= tx_mem;
      s1_rd_mem_q <= rd_mem;
      s1_oob_q    <= raddr_oob;
      s1_rate_q   <= rate_d;
      s1_fmt_q    <= fmt_d;
      s1_phase_q  <= dmx_pkg::phase_code(phase_d);
    end
  end

  assign mem_byte = s1_oob_q ? '0 : ram_rdata;

  // result register
  logic                        out_tx_v_q, out_rate_q, out_fmt_q;
  logic [dmx_pkg::BYTE_W-1:0]  out_tx_byte_q, out_rd_q;
  logic [dmx_pkg::PHASE_W-1:0] out_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_adv | (out_valid_q & ~out_if.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_tx_v_q    <= s1_tx_v_q;
      out_tx_byte_q <= s1_tx_mem_q ? mem_byte : '0;
      out_rd_q      <= s1_rd_mem_q ? mem_byte : '0;
      out_rate_q    <= s1_rate_q;
      out_fmt_q     <= s1_fmt_q;
      out_phase_q   <= s1_phase_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.tx_valid     = out_tx_v_q;
  assign out_if.tx_byte      = out_tx_byte_q;
  assign out_if.line_rate    = out_rate_q;
  assign out_if.frame_format = out_fmt_q;
  assign out_if.read_value   = out_rd_q;
  assign out_if.frame_phase  = out_phase_q;

endmodule

### tb/tb_dmx512_frame_transmit_sequencer.sv
// Testbench for the DMX512 frame transmit sequencer: directed and random requests.
module tb_dmx512_frame_transmit_sequencer;
  import dmx_pkg::*;

  localparam int unsigned SLOT_MAX = MAX_SLOTS_DEF;
  localparam int unsigned IDX_TOP  = (1 << IDX_W) - 1;

  typedef struct packed {
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
    logic               line_rate;
    logic               frame_format;
    logic [BYTE_W-1:0]  read_value;
    logic [PHASE_W-1:0] frame_phase;
  } dmx_result_t;

  logic clk_i;
  logic rst_ni;

  dmx_in_if  req_ch ();
  dmx_out_if res_ch ();
  dmx_cfg_if cfg_ch ();

  dmx512_frame_transmit_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  logic [PHASE_W-1:0] seq_phase;
  logic [IDX_W-1:0]   seq_slot;
  logic [WCNT_W-1:0]  seq_wait;
  logic               seq_rate;
  logic               seq_fmt;
  logic [BYTE_W-1:0]  slot_mem [0:SLOT_MAX];
  logic [IDX_W-1:0]   cfg_slots;
  logic [WAIT_W-1:0]  cfg_tail_wait;
  logic [WAIT_W-1:0]  cfg_break_hold;

  dmx_result_t due_outputs [$];
  int          fail_count = 0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;
  int          results_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] slot_byte(logic [IDX_W-1:0] idx);
    return (idx <= SLOT_MAX) ? slot_mem[idx] : '0;
  endfunction

  function automatic dmx_result_t frame_step(func_e f, logic [IDX_W-1:0] idx,
                                             logic [BYTE_W-1:0] val);
    dmx_result_t r;
    r = '0;
    case (f)
      FUNC_WRITE: begin
        if (idx <= SLOT_MAX) slot_mem[idx] = val;
      end
      FUNC_READ: begin
        r.read_value = slot_byte(idx);
      end
      FUNC_RESTART: begin
        seq_phase = CODE_BREAK;
        seq_wait  = '0;
        seq_rate  = RATE_BREAK;
        seq_fmt   = FMT_8E1;
      end
      default: begin
        case (seq_phase)
          CODE_START: begin
            seq_rate   = RATE_DATA;
            seq_fmt    = FMT_8N2;
            r.tx_valid = 1'b1;
            r.tx_byte  = slot_byte('0);
            seq_slot   = IDX_W'(1);
            seq_phase  = CODE_DATA;
          end
          CODE_DATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = slot_byte(seq_slot);
            seq_slot   = seq_slot + 1'b1;
            if (seq_slot > cfg_slots) begin
              seq_phase = CODE_IDLE;
              seq_wait  = '0;
            end
          end
          CODE_IDLE: begin
            if (seq_wait < 8'd255) seq_wait = seq_wait + 1'b1;
            if (seq_wait > cfg_tail_wait) seq_phase = CODE_BREAK;
          end
          CODE_BREAK_SENT: begin
            if (seq_wait < 8'd255) seq_wait = seq_wait + 1'b1;
            if (seq_wait > cfg_break_hold) seq_phase = CODE_START;
          end
          default: begin
            seq_rate   = RATE_BREAK;
            seq_fmt    = FMT_8E1;
            r.tx_valid = 1'b1;
            r.tx_byte  = '0;
            seq_wait   = '0;
            seq_phase  = CODE_BREAK_SENT;
          end
        endcase
      end
    endcase
    r.line_rate    = seq_rate;
    r.frame_format = seq_fmt;
    r.frame_phase  = seq_phase;
    return r;
  endfunction

  // one request; the expected output is worked out at the accepting edge
  task automatic send_request(func_e f, logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
    int gap;
    gap = sender_steady ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.slot_index <= idx;
    req_ch.slot_value <= val;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    due_outputs.push_back(frame_step(f, idx, val));
    @(negedge clk_i);
  endtask

  task automatic run_empty(int n);
    repeat (n) send_request(FUNC_EMPTY, IDX_W'($urandom_range(0, IDX_TOP)),
                            BYTE_W'($urandom_range(0, 255)));
  endtask

  // only once the block has drained
  task automatic write_register(cfg_reg_e r, logic [CFG_DAT_W-1:0] d);
    req_ch.valid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    case (r)
      REG_SLOT_COUNT: begin
        if (d < MIN_SLOTS) cfg_slots = IDX_W'(MIN_SLOTS);
        else if (d > SLOT_MAX) cfg_slots = IDX_W'(SLOT_MAX);
        else cfg_slots = d;
      end
      REG_DATA_END_WAIT: cfg_tail_wait = d[WAIT_W-1:0];
      REG_BREAK_WAIT:    cfg_break_hold = d[WAIT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : result_check
    dmx_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (due_outputs.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = due_outputs.pop_front();
          check_field("tx_valid", want.tx_valid, res_ch.tx_valid);
          check_field("tx_byte", want.tx_byte, res_ch.tx_byte);
          check_field("line_rate", want.line_rate, res_ch.line_rate);
          check_field("frame_format", want.frame_format, res_ch.frame_format);
          check_field("read_value", want.read_value, res_ch.read_value);
          check_field("frame_phase", want.frame_phase, res_ch.frame_phase);
        end
      end
    end
  end

  initial begin : result_stall
    logic next_ready;
    int   stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (results_hold > 0) begin
        results_hold--;
        next_ready = 1'b0;
      end else if (receiver_steady) begin
        next_ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
      @(negedge clk_i);
      res_ch.ready <= next_ready;
    end
  end

  task automatic test_slot_access();
    send_request(FUNC_READ, '0, 8'h00);
    send_request(FUNC_READ, IDX_W'(SLOT_MAX), 8'h00);
    send_request(FUNC_WRITE, '0, 8'hFF);
    send_request(FUNC_WRITE, IDX_W'(SLOT_MAX), 8'hA5);
    send_request(FUNC_WRITE, IDX_W'(SLOT_MAX + 1), 8'h77);
    send_request(FUNC_WRITE, IDX_W'(IDX_TOP), 8'h5A);
    send_request(FUNC_WRITE, IDX_W'(1), 8'h00);
    send_request(FUNC_READ, '0, 8'hFF);
    send_request(FUNC_READ, IDX_W'(SLOT_MAX), 8'h00);
    send_request(FUNC_READ, IDX_W'(SLOT_MAX + 1), 8'h00);
    send_request(FUNC_READ, IDX_W'(IDX_TOP), 8'hFF);
    send_request(FUNC_READ, IDX_W'(1), 8'h00);
  endtask

  // break, break hold and the opening slots on the reset register values
  task automatic test_reset_frame();
    run_empty(1 + 81 + 1 + 8);
  endtask

  task automatic test_restart();
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(24));
    write_register(REG_DATA_END_WAIT, CFG_DAT_W'(3));
    write_register(REG_BREAK_WAIT, CFG_DAT_W'(3));
    send_request(FUNC_RESTART, '0, 8'h00);
    run_empty(3);
    send_request(FUNC_RESTART, IDX_W'(IDX_TOP), 8'hFF);
    run_empty(1 + 4 + 1 + 5);
    send_request(FUNC_RESTART, '0, 8'h00);
    run_empty(1 + 4 + 1 + 24 + 2);
    send_request(FUNC_RESTART, '0, 8'h00);
    run_empty(2);
  endtask

  task automatic test_wait_extremes();
    write_register(REG_SLOT_COUNT, '0);
    write_register(REG_DATA_END_WAIT, '0);
    write_register(REG_BREAK_WAIT, '0);
    send_request(FUNC_RESTART, '0, 8'h00);
    run_empty(60);
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(IDX_TOP));
    write_register(REG_DATA_END_WAIT, CFG_DAT_W'(127));
    write_register(REG_BREAK_WAIT, CFG_DAT_W'(127));
    send_request(FUNC_RESTART, '0, 8'h00);
    run_empty(1 + 128 + 1 + 3);
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(SLOT_MAX));
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(24));
    run_empty(21 + 128 + 3);
  endtask

  task automatic test_slot_count_lowered();
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(64));
    write_register(REG_DATA_END_WAIT, CFG_DAT_W'(2));
    write_register(REG_BREAK_WAIT, CFG_DAT_W'(2));
    send_request(FUNC_RESTART, '0, 8'h00);
    run_empty(1 + 3 + 1 + 40);
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(24));
    run_empty(1 + 3 + 6);
  endtask

  task automatic test_backpressure();
    write_register(REG_SLOT_COUNT, CFG_DAT_W'(40));
    write_register(REG_DATA_END_WAIT, CFG_DAT_W'(1));
    write_register(REG_BREAK_WAIT, CFG_DAT_W'(1));
    sender_steady = 1'b1;
    results_hold  = 300;
    repeat (20) send_request(FUNC_WRITE, IDX_W'($urandom_range(0, 40)),
                             BYTE_W'($urandom_range(0, 255)));
    run_empty(20);
    sender_steady = 1'b0;
  endtask

  task automatic test_random();
    int                r;
    func_e             f;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] val;
    for (int round = 0; round < 5; round++) begin
      r = $urandom_range(0, 9);
      write_register(REG_SLOT_COUNT, (r < 7) ? CFG_DAT_W'($urandom_range(24, 64)) :
                                     (r < 8) ? CFG_DAT_W'($urandom_range(0, 23)) :
                                               CFG_DAT_W'($urandom_range(0, IDX_TOP)));
      write_register(REG_DATA_END_WAIT, ($urandom_range(0, 3) == 0) ?
                     CFG_DAT_W'($urandom_range(0, IDX_TOP)) : CFG_DAT_W'($urandom_range(0, 15)));
      write_register(REG_BREAK_WAIT, ($urandom_range(0, 3) == 0) ?
                     CFG_DAT_W'($urandom_range(0, IDX_TOP)) : CFG_DAT_W'($urandom_range(0, 15)));
      sender_steady   = (round == 2);
      receiver_steady = (round == 2);
      repeat (24) begin
        r = $urandom_range(0, 99);
        if (r < 75) f = FUNC_EMPTY;
        else if (r < 88) f = FUNC_WRITE;
        else if (r < 99) f = FUNC_READ;
        else f = FUNC_RESTART;
        if ($urandom_range(0, 7) == 0) idx = IDX_W'($urandom_range(0, IDX_TOP));
        else idx = IDX_W'($urandom_range(0, cfg_slots));
        val = BYTE_W'($urandom_range(0, 255));
        send_request(f, idx, val);
      end
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_EMPTY;
    req_ch.slot_index = '0;
    req_ch.slot_value = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_SLOT_COUNT;
    cfg_ch.data       = '0;
    res_ch.ready      = 1'b0;
    seq_phase         = CODE_BREAK;
    seq_slot          = '0;
    seq_wait          = '0;
    seq_rate          = RATE_BREAK;
    seq_fmt           = FMT_8E1;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    cfg_slots         = IDX_W'(SLOT_MAX);
    cfg_tail_wait     = DATA_END_WAIT_RST;
    cfg_break_hold    = BREAK_WAIT_RST;
    rst_ni            = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_slot_access();
    test_reset_frame();
    test_restart();
    test_wait_extremes();
    test_slot_count_lowered();
    test_backpressure();
    test_random();

    req_ch.valid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
